[rtl/yuvrgba_pkg.sv]
`timescale 1ns / 1ps

package yuvrgba_pkg;

  localparam int ProdW    = 22;
  localparam int FixBits  = 10;
  localparam int SumW     = 26;
  localparam int DivSteps = 8;
  localparam int CfgW     = 24;

  localparam int StgProd   = 0;
  localparam int StgRgb    = 1;
  localparam int StgSq     = 2;
  localparam int StgWt     = 3;
  localparam int StgSum    = 4;
  localparam int DivBase   = 5;
  localparam int StgFall   = DivBase + DivSteps;
  localparam int StgPack   = StgFall + 1;
  localparam int NumStages = StgPack + 1;

  localparam logic signed [ProdW-1:0] CoefY  = 22'sd1192;
  localparam logic signed [ProdW-1:0] CoefRv = 22'sd1634;
  localparam logic signed [ProdW-1:0] CoefGu = 22'sd400;
  localparam logic signed [ProdW-1:0] CoefGv = 22'sd833;
  localparam logic signed [ProdW-1:0] CoefBu = 22'sd2066;
  localparam logic signed [ProdW-1:0] FixHalf = 22'sd512;

  typedef enum logic [1:0] {
    AlphaPass   = 2'd0,
    AlphaFill   = 2'd1,
    AlphaThresh = 2'd2,
    AlphaKey    = 2'd3
  } alpha_mode_e;

  typedef enum logic [2:0] {
    RegByteOrder = 3'd0,
    RegAlphaMode = 3'd1,
    RegLowThr    = 3'd2,
    RegHighThr   = 3'd3,
    RegGain      = 3'd4,
    RegKeyColor  = 3'd5,
    RegKeyWeight = 3'd6,
    RegWeightDiv = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic        byte_order;
    alpha_mode_e alpha_mode;
    logic [7:0]  low_thr;
    logic [7:0]  high_thr;
    logic [15:0] gain;
    logic [23:0] key_color;
    logic [23:0] key_weights;
    logic [15:0] divisor;
  } cfg_t;

  typedef struct packed {
    logic [7:0] luma_top_left;
    logic [7:0] luma_top_right;
    logic [7:0] luma_bottom_left;
    logic [7:0] luma_bottom_right;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
    logic [7:0] alpha_top_left;
    logic [7:0] alpha_top_right;
    logic [7:0] alpha_bottom_left;
    logic [7:0] alpha_bottom_right;
  } yuv_in_t;

  typedef struct packed {
    logic [31:0] pixel_top_left;
    logic [31:0] pixel_top_right;
    logic [31:0] pixel_bottom_left;
    logic [31:0] pixel_bottom_right;
  } rgba_out_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } side_t;

  function automatic logic [7:0] to_byte(input logic signed [ProdW-1:0] t);
    logic [7:0] res;
    if (t[ProdW-1]) begin
      res = 8'h00;
    end else if (|t[ProdW-1:FixBits+8]) begin
      res = 8'hFF;
    end else begin
      res = t[FixBits+7:FixBits];
    end
    return res;
  endfunction

  function automatic logic [7:0] abs_diff(input logic [7:0] x, input logic [7:0] y);
    return (x > y) ? (x - y) : (y - x);
  endfunction

endpackage

[rtl/yuvrgba_lane.sv]
`timescale 1ns / 1ps

module yuvrgba_lane import yuvrgba_pkg::*; (
  input  logic                 clk_i,
  input  logic [NumStages-1:0] en_i,
  input  cfg_t                 cfg_i,
  input  logic [7:0]           luma_i,
  input  logic [7:0]           cb_i,
  input  logic [7:0]           cr_i,
  input  logic [7:0]           alpha_i,
  output logic [31:0]          pixel_o
);

  // products
  logic signed [8:0]       c_s, d_s, e_s;
  logic signed [ProdW-1:0] cy_q, rv_q, gu_q, gv_q, bu_q;
  logic [7:0]              a0_q;

  assign c_s = $signed({1'b0, luma_i}) - 9'sd16;
  assign d_s = $signed({1'b0, cb_i}) - 9'sd128;
  assign e_s = $signed({1'b0, cr_i}) - 9'sd128;

  always_ff @(posedge clk_i) begin
    if (en_i[StgProd]) begin
      cy_q <= ProdW'(c_s) * CoefY;
      rv_q <= ProdW'(e_s) * CoefRv;
      gu_q <= ProdW'(d_s) * CoefGu;
      gv_q <= ProdW'(e_s) * CoefGv;
      bu_q <= ProdW'(d_s) * CoefBu;
      a0_q <= alpha_i;
    end
  end

  // rgb bytes and side chain
  side_t side_q [StgFall:StgRgb];
  logic signed [ProdW-1:0] tr, tg, tb;

  assign tr = cy_q + rv_q + FixHalf;
  assign tg = cy_q - gu_q - gv_q + FixHalf;
  assign tb = cy_q + bu_q + FixHalf;

  always_ff @(posedge clk_i) begin
    if (en_i[StgRgb]) begin
      side_q[StgRgb] <= '{r: to_byte(tr), g: to_byte(tg), b: to_byte(tb), a: a0_q};
    end
  end

  for (genvar k = StgRgb + 1; k <= StgFall; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // squared distances
  logic [7:0]  dr, dg, db;
  logic [15:0] sqr_q, sqg_q, sqb_q;

  assign dr = abs_diff(side_q[StgRgb].r, cfg_i.key_color[7:0]);
  assign dg = abs_diff(side_q[StgRgb].g, cfg_i.key_color[15:8]);
  assign db = abs_diff(side_q[StgRgb].b, cfg_i.key_color[23:16]);

  always_ff @(posedge clk_i) begin
    if (en_i[StgSq]) begin
      sqr_q <= 16'(dr) * 16'(dr);
      sqg_q <= 16'(dg) * 16'(dg);
      sqb_q <= 16'(db) * 16'(db);
    end
  end

  // weighted
  logic [23:0] wr_q, wg_q, wb_q;

  always_ff @(posedge clk_i) begin
    if (en_i[StgWt]) begin
      wr_q <= 24'(sqr_q) * 24'(cfg_i.key_weights[7:0]);
      wg_q <= 24'(sqg_q) * 24'(cfg_i.key_weights[15:8]);
      wb_q <= 24'(sqb_q) * 24'(cfg_i.key_weights[23:16]);
    end
  end

  // sum and saturation test
  logic [SumW-1:0] sum_d, sum_q;
  logic            sat_q;

  assign sum_d = SumW'(wr_q) + SumW'(wg_q) + SumW'(wb_q);

  always_ff @(posedge clk_i) begin
    if (en_i[StgSum]) begin
      sum_q <= sum_d;
      sat_q <= (sum_d >= SumW'({cfg_i.divisor, 8'h00}));
    end
  end

  // restoring division, one quotient bit per stage
  logic [SumW-1:0] rem_q  [DivSteps-1];
  logic [7:0]      quo_q  [DivSteps];
  logic            dsat_q [DivSteps];

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    logic [SumW-1:0] rem_in, dsh;
    logic [7:0]      quo_in;
    logic            sat_in, ge;

    if (i == 0) begin : g_first
      assign rem_in = sum_q;
      assign quo_in = 8'h00;
      assign sat_in = sat_q;
    end else begin : g_next
      assign rem_in = rem_q[i-1];
      assign quo_in = quo_q[i-1];
      assign sat_in = dsat_q[i-1];
    end

    assign dsh = SumW'(cfg_i.divisor) << (DivSteps - 1 - i);
    assign ge  = (rem_in >= dsh);

    always_ff @(posedge clk_i) begin
      if (en_i[DivBase+i]) begin
        quo_q[i]  <= ge ? (quo_in | (8'h01 << (DivSteps - 1 - i))) : quo_in;
        dsat_q[i] <= sat_in;
      end
    end

    if (i < DivSteps - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i[DivBase+i]) begin
          rem_q[i] <= ge ? (rem_in - dsh) : rem_in;
        end
      end
    end
  end

  // falloff product
  logic [7:0]  key_dist, asel;
  logic [23:0] prod_q;
  logic        le_q, ge_q;

  assign key_dist = dsat_q[DivSteps-1] ? 8'hFF : quo_q[DivSteps-1];
  assign asel = (cfg_i.alpha_mode == AlphaKey) ? key_dist : side_q[StgFall-1].a;

  always_ff @(posedge clk_i) begin
    if (en_i[StgFall]) begin
      prod_q <= 24'(asel) * 24'(cfg_i.gain);
      le_q   <= (asel <= cfg_i.low_thr);
      ge_q   <= (asel >= cfg_i.high_thr);
    end
  end

  // final alpha and packing
  logic [7:0]  fo, al;
  logic [31:0] pixel_q;

  always_comb begin
    priority if (le_q) begin
      fo = 8'h00;
    end else if (ge_q) begin
      fo = 8'hFF;
    end else if (|prod_q[23:16]) begin
      fo = 8'hFF;
    end else begin
      fo = prod_q[15:8];
    end

    unique case (cfg_i.alpha_mode)
      AlphaPass:   al = side_q[StgFall].a;
      AlphaFill:   al = 8'hFF;
      AlphaThresh: al = fo;
      AlphaKey:    al = fo;
      default:     al = fo;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[StgPack]) begin
      pixel_q <= cfg_i.byte_order
          ? {al, side_q[StgFall].r, side_q[StgFall].g, side_q[StgFall].b}
          : {al, side_q[StgFall].b, side_q[StgFall].g, side_q[StgFall].r};
    end
  end

  assign pixel_o = pixel_q;

endmodule

[rtl/yuv420_block_to_rgba_alpha.sv]
`timescale 1ns / 1ps
// channel   direction  handshake             payload
// cfg       in         cfg_we_i              cfg_addr_i, cfg_wdata_i
// in        in         in_valid_i/in_ready_o in_data_i (yuv_in_t)
// out       out        out_valid_o/out_ready_i out_data_o (rgba_out_t)
//
// one 2x2 block per cycle while out_ready_i stays high, through fifteen
// register stages: products, clamp, squares, weights, sum, eight divider bit
// stages, falloff and packing; out_valid_o is the packing stage's valid bit
// reset clears stage valid bits and config registers to their defaults
// each stage advances when it is empty or the next one advances, so bubbles
// collapse and input is taken while a finished transaction waits at the output

module yuv420_block_to_rgba_alpha import yuvrgba_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_addr_i,
  input  logic [CfgW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  yuv_in_t         in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rgba_out_t       out_data_o
);

  logic        byte_order_q;
  alpha_mode_e alpha_mode_q;
  logic [7:0]  low_thr_q, high_thr_q;
  logic [15:0] gain_q, div_q;
  logic [23:0] key_color_q, key_weights_q;
  cfg_t        cfg;
  reg_idx_e    idx;

  assign idx = reg_idx_e'(cfg_addr_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_order_q  <= 1'b0;
      alpha_mode_q  <= AlphaPass;
      low_thr_q     <= 8'd0;
      high_thr_q    <= 8'd255;
      gain_q        <= 16'd256;
      key_color_q   <= 24'h000000;
      key_weights_q <= 24'h010101;
      div_q         <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (idx)
        RegByteOrder: byte_order_q  <= cfg_wdata_i[0];
        RegAlphaMode: alpha_mode_q  <= alpha_mode_e'(cfg_wdata_i[1:0]);
        RegLowThr:    low_thr_q     <= cfg_wdata_i[7:0];
        RegHighThr:   high_thr_q    <= cfg_wdata_i[7:0];
        RegGain:      gain_q        <= cfg_wdata_i[15:0];
        RegKeyColor:  key_color_q   <= cfg_wdata_i[23:0];
        RegKeyWeight: key_weights_q <= cfg_wdata_i[23:0];
        RegWeightDiv: div_q         <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.byte_order  = byte_order_q;
    cfg.alpha_mode  = alpha_mode_q;
    cfg.low_thr     = low_thr_q;
    cfg.high_thr    = high_thr_q;
    cfg.gain        = gain_q;
    cfg.key_color   = key_color_q;
    cfg.key_weights = key_weights_q;
    // zero divisor acts as one
    cfg.divisor     = (div_q == 16'd0) ? 16'd1 : div_q;
  end

  // stage valids and advance chain
  logic [NumStages-1:0] v_q, en;

  always_comb begin
    en[NumStages-1] = !v_q[NumStages-1] || out_ready_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[NumStages-1];

  yuvrgba_lane u_lane_tl (
    .clk_i   (clk_i),
    .en_i    (en),
    .cfg_i   (cfg),
    .luma_i  (in_data_i.luma_top_left),
    .cb_i    (in_data_i.chroma_blue),
    .cr_i    (in_data_i.chroma_red),
    .alpha_i (in_data_i.alpha_top_left),
    .pixel_o (out_data_o.pixel_top_left)
  );

  yuvrgba_lane u_lane_tr (
    .clk_i   (clk_i),
    .en_i    (en),
    .cfg_i   (cfg),
    .luma_i  (in_data_i.luma_top_right),
    .cb_i    (in_data_i.chroma_blue),
    .cr_i    (in_data_i.chroma_red),
    .alpha_i (in_data_i.alpha_top_right),
    .pixel_o (out_data_o.pixel_top_right)
  );

  yuvrgba_lane u_lane_bl (
    .clk_i   (clk_i),
    .en_i    (en),
    .cfg_i   (cfg),
    .luma_i  (in_data_i.luma_bottom_left),
    .cb_i    (in_data_i.chroma_blue),
    .cr_i    (in_data_i.chroma_red),
    .alpha_i (in_data_i.alpha_bottom_left),
    .pixel_o (out_data_o.pixel_bottom_left)
  );

  yuvrgba_lane u_lane_br (
    .clk_i   (clk_i),
    .en_i    (en),
    .cfg_i   (cfg),
    .luma_i  (in_data_i.luma_bottom_right),
    .cb_i    (in_data_i.chroma_blue),
    .cr_i    (in_data_i.chroma_red),
    .alpha_i (in_data_i.alpha_bottom_right),
    .pixel_o (out_data_o.pixel_bottom_right)
  );

  // accepted transaction lands in the first stage
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> v_q[0])
    else $error("accepted transaction missing from first stage");

  // input only blocks when every stage is full and the output stalls
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (&v_q) && !out_ready_i)
    else $error("input blocked with room in pipeline");

  // transactions in flight are conserved
  a_conserve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> ($countones(v_q) == $countones($past(v_q))
      + int'($past(in_valid_i && in_ready_o))
      - int'($past(out_valid_o && out_ready_i))))
    else $error("transaction lost or duplicated in pipeline");

endmodule

[bench/yuv420_block_to_rgba_alpha_tb.sv]
`timescale 1ns / 1ps

module yuv420_block_to_rgba_alpha_tb;
  import yuvrgba_pkg::*;

  localparam int MulY  = 1192;
  localparam int MulRv = 1634;
  localparam int MulGu = 400;
  localparam int MulGv = 833;
  localparam int MulBu = 2066;
  localparam int Half  = 512;
  localparam int NumPhases = 12;
  localparam int BlocksPerPhase = 96;
  localparam int HoldAfter = 200;
  localparam int HoldCycles = 80;
  localparam int CycleLimit = 200000;

  localparam cfg_t ResetCfg = '{
    byte_order: 1'b0, alpha_mode: AlphaPass, low_thr: 8'd0, high_thr: 8'd255,
    gain: 16'd256, key_color: 24'd0, key_weights: 24'h010101, divisor: 16'd1
  };

  typedef struct packed {
    logic      typed;
    yuv_in_t   blk;
    rgba_out_t pix;
  } probe_t;

  localparam int NumProbes = 16;
  localparam probe_t Probes [NumProbes] = '{
    '{1'b1, {8'h10, 8'h10, 8'h10, 8'h10, 8'h80, 8'h80, 8'h00, 8'hff, 8'h80, 8'h01},
      {32'h00000000, 32'hff000000, 32'h80000000, 32'h01000000}},
    '{1'b1, {8'heb, 8'heb, 8'heb, 8'heb, 8'h80, 8'h80, 8'hff, 8'hff, 8'hff, 8'hff},
      {32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff}},
    '{1'b1, {8'h00, 8'hff, 8'h10, 8'heb, 8'h80, 8'h80, 8'h00, 8'h5a, 8'ha5, 8'hff},
      {32'h00000000, 32'h5affffff, 32'ha5000000, 32'hffffffff}},
    '{1'b0, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h55, 8'haa, 8'h55, 8'haa}, '0},
    '{1'b0, {8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'haa, 8'h55, 8'haa, 8'h55}, '0},
    '{1'b0, {8'h80, 8'h10, 8'heb, 8'hff, 8'h00, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00}, '0},
    '{1'b0, {8'h80, 8'h80, 8'h80, 8'h80, 8'hff, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff}, '0},
    '{1'b0, {8'h10, 8'h20, 8'h40, 8'h80, 8'h5a, 8'hf0, 8'h01, 8'h02, 8'h04, 8'h08}, '0},
    '{1'b0, {8'hfe, 8'h7f, 8'h01, 8'hc3, 8'h81, 8'h7f, 8'h10, 8'h20, 8'h40, 8'h80}, '0},
    '{1'b0, {8'h51, 8'ha2, 8'h28, 8'h91, 8'h36, 8'h22, 8'hfe, 8'hfd, 8'hfb, 8'hf7}, '0},
    '{1'b0, {8'h6e, 8'h6e, 8'h6e, 8'h6e, 8'h80, 8'h80, 8'h7f, 8'h80, 8'h7f, 8'h80}, '0},
    '{1'b0, {8'heb, 8'h10, 8'heb, 8'h10, 8'h10, 8'hf0, 8'hef, 8'hdf, 8'hbf, 8'h7f}, '0},
    '{1'b0, {8'h3c, 8'h3c, 8'hc8, 8'hc8, 8'hf0, 8'h10, 8'h00, 8'hff, 8'h00, 8'hff}, '0},
    '{1'b0, {8'h01, 8'h02, 8'hfd, 8'hfe, 8'h7f, 8'h81, 8'h80, 8'h80, 8'h80, 8'h80}, '0},
    '{1'b0, {8'h00, 8'h00, 8'hff, 8'hff, 8'h00, 8'hff, 8'h0f, 8'hf0, 8'h3c, 8'hc3}, '0},
    '{1'b0, {8'hff, 8'hff, 8'h00, 8'h00, 8'hff, 8'h00, 8'h33, 8'hcc, 8'h33, 8'hcc}, '0}
  };

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [2:0]      cfg_addr_i = '0;
  logic [CfgW-1:0] cfg_wdata_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  yuv_in_t         in_data_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  rgba_out_t       out_data_o;

  cfg_t      setting = ResetCfg;
  rgba_out_t pixels_due [$];
  rgba_out_t oldest_due;
  int        tx_idle_pct = 11;
  int        rx_idle_pct = 72;
  int        mismatch_count = 0;
  int        blocks_checked = 0;
  int        cycle_count = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;

  yuv420_block_to_rgba_alpha dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [7:0] sat_channel(int t);
    if (t < 0) return 8'h00;
    t = t >>> 10;
    return (t > 255) ? 8'hff : t[7:0];
  endfunction

  function automatic logic [7:0] falloff_alpha(int unsigned a, cfg_t c);
    int unsigned m;
    if (a <= c.low_thr) return 8'h00;
    if (a >= c.high_thr) return 8'hff;
    m = (a * c.gain) >> 8;
    return (m > 255) ? 8'hff : m[7:0];
  endfunction

  function automatic logic [7:0] key_alpha_of(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                               cfg_t c);
    int unsigned dr, dg, db, total, div, key_dist;
    dr = (r > c.key_color[7:0]) ? r - c.key_color[7:0] : c.key_color[7:0] - r;
    dg = (g > c.key_color[15:8]) ? g - c.key_color[15:8] : c.key_color[15:8] - g;
    db = (b > c.key_color[23:16]) ? b - c.key_color[23:16] : c.key_color[23:16] - b;
    total = dr * dr * c.key_weights[7:0] + dg * dg * c.key_weights[15:8]
          + db * db * c.key_weights[23:16];
    div = (c.divisor == 16'd0) ? 1 : c.divisor;
    key_dist = total / div;
    if (key_dist > 255) key_dist = 255;
    return falloff_alpha(key_dist, c);
  endfunction

  function automatic logic [31:0] convert_pixel(logic [7:0] y, logic [7:0] u, logic [7:0] v,
                                                logic [7:0] a, cfg_t c);
    int cy, cu, cv;
    logic [7:0] r, g, b, al;
    cu = int'(u) - 128;
    cv = int'(v) - 128;
    cy = MulY * (int'(y) - 16);
    r = sat_channel(cy + MulRv * cv + Half);
    g = sat_channel(cy - MulGu * cu - MulGv * cv + Half);
    b = sat_channel(cy + MulBu * cu + Half);
    case (c.alpha_mode)
      AlphaPass:   al = a;
      AlphaFill:   al = 8'hff;
      AlphaThresh: al = falloff_alpha(a, c);
      default:     al = key_alpha_of(r, g, b, c);
    endcase
    return c.byte_order ? {al, r, g, b} : {al, b, g, r};
  endfunction

  function automatic rgba_out_t convert_block(yuv_in_t k, cfg_t c);
    rgba_out_t p;
    p.pixel_top_left = convert_pixel(k.luma_top_left, k.chroma_blue, k.chroma_red,
                                     k.alpha_top_left, c);
    p.pixel_top_right = convert_pixel(k.luma_top_right, k.chroma_blue, k.chroma_red,
                                      k.alpha_top_right, c);
    p.pixel_bottom_left = convert_pixel(k.luma_bottom_left, k.chroma_blue, k.chroma_red,
                                        k.alpha_bottom_left, c);
    p.pixel_bottom_right = convert_pixel(k.luma_bottom_right, k.chroma_blue, k.chroma_red,
                                         k.alpha_bottom_right, c);
    return p;
  endfunction

  function automatic logic [7:0] near_byte(logic [7:0] centre, int spread);
    int v;
    v = int'(centre) + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // near blocks sit around the key color so the distance lands in the falloff range
  function automatic yuv_in_t random_block(bit near, logic [7:0] by, logic [7:0] bu,
                                           logic [7:0] bv);
    logic [95:0] bits;
    yuv_in_t k;
    bits = {$urandom(), $urandom(), $urandom()};
    k = bits[79:0];
    if (near) begin
      k.luma_top_left = near_byte(by, 8);
      k.luma_top_right = near_byte(by, 8);
      k.luma_bottom_left = near_byte(by, 8);
      k.luma_bottom_right = near_byte(by, 8);
      k.chroma_blue = near_byte(bu, 8);
      k.chroma_red = near_byte(bv, 8);
    end
    return k;
  endfunction

  function automatic cfg_t make_setting(int k, logic [23:0] key_rgb);
    cfg_t c;
    c = ResetCfg;
    case (k)
      0: c.byte_order = 1'b1;
      1: c.alpha_mode = AlphaFill;
      2: begin
        c.alpha_mode = AlphaThresh;
        c.low_thr = 8'h40;
        c.high_thr = 8'hc0;
        c.gain = 16'h0180;
      end
      3: begin
        c.alpha_mode = AlphaThresh;
        c.byte_order = 1'b1;
        c.low_thr = 8'd200;
        c.high_thr = 8'd100;
        c.gain = 16'hffff;
      end
      4: begin
        c.alpha_mode = AlphaThresh;
        c.low_thr = 8'd0;
        c.high_thr = 8'd255;
        c.gain = 16'h0000;
      end
      5: begin
        c.alpha_mode = AlphaKey;
        c.key_color = key_rgb;
        c.low_thr = 8'd8;
        c.high_thr = 8'd200;
        c.divisor = 16'd4;
      end
      6: begin
        c.alpha_mode = AlphaKey;
        c.byte_order = 1'b1;
        c.key_color = key_rgb;
        c.key_weights = 24'hffffff;
        c.divisor = 16'hffff;
        c.gain = 16'hffff;
      end
      7: begin
        c.alpha_mode = AlphaKey;
        c.key_color = key_rgb;
        c.key_weights = 24'($urandom_range(24'h0f0f0f));
        c.divisor = 16'd0;
        c.low_thr = 8'($urandom_range(64));
        c.high_thr = 8'($urandom_range(255, 128));
        c.gain = 16'($urandom);
      end
      8: begin
        c.alpha_mode = AlphaKey;
        c.key_color = 24'hffffff;
        c.key_weights = 24'h000000;
        c.byte_order = 1'($urandom);
      end
      9: begin
        c.alpha_mode = AlphaKey;
        c.key_color = 24'h000000;
        c.key_weights = 24'h040201;
        c.divisor = 16'h0100;
        c.low_thr = 8'h20;
        c.high_thr = 8'hf0;
        c.gain = 16'h0200;
      end
      default: begin
        c.byte_order = 1'($urandom);
        c.alpha_mode = alpha_mode_e'($urandom_range(3));
        c.low_thr = 8'($urandom);
        c.high_thr = 8'($urandom);
        c.gain = 16'($urandom);
        c.key_color = ($urandom_range(1) == 0) ? key_rgb : 24'($urandom);
        c.key_weights = 24'($urandom);
        c.divisor = 16'($urandom_range(64));
      end
    endcase
    return c;
  endfunction

  task automatic put_reg(input reg_idx_e idx, input logic [23:0] val, input logic [23:0] used);
    logic [23:0] junk;
    junk = 24'($urandom);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= (junk & ~used) | (val & used);
    @(posedge clk_i);
  endtask

  task automatic apply_config(input cfg_t c);
    put_reg(RegByteOrder, 24'(c.byte_order), 24'h000001);
    put_reg(RegAlphaMode, 24'(c.alpha_mode), 24'h000003);
    put_reg(RegLowThr, 24'(c.low_thr), 24'h0000ff);
    put_reg(RegHighThr, 24'(c.high_thr), 24'h0000ff);
    put_reg(RegGain, 24'(c.gain), 24'h00ffff);
    put_reg(RegKeyColor, c.key_color, 24'hffffff);
    put_reg(RegKeyWeight, c.key_weights, 24'hffffff);
    put_reg(RegWeightDiv, 24'(c.divisor), 24'h00ffff);
    cfg_we_i <= 1'b0;
    setting = c;
  endtask

  task automatic push_block(input yuv_in_t k, input logic typed, input rgba_out_t pix);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= k;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    pixels_due.push_back(typed ? pix : convert_block(k, setting));
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver, with one long hold-off to back the pipeline up into the input
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!hold_done && blocks_checked >= HoldAfter) begin
      hold_done = 1'b1;
      hold_left = HoldCycles;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pixels_due.size() == 0) begin
        $error("output transaction with nothing expected: %h", out_data_o);
        mismatch_count++;
      end else begin
        oldest_due = pixels_due.pop_front();
        compare_field("pixel_top_left", oldest_due.pixel_top_left,
                      out_data_o.pixel_top_left);
        compare_field("pixel_top_right", oldest_due.pixel_top_right,
                      out_data_o.pixel_top_right);
        compare_field("pixel_bottom_left", oldest_due.pixel_bottom_left,
                      out_data_o.pixel_bottom_left);
        compare_field("pixel_bottom_right", oldest_due.pixel_bottom_right,
                      out_data_o.pixel_bottom_right);
      end
      blocks_checked++;
    end
  end

  initial begin
    logic [7:0] base_y, base_u, base_v;
    logic [31:0] key_pix;
    cfg_t c;
    bit near;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumProbes; i++) begin
      push_block(Probes[i].blk, Probes[i].typed, Probes[i].pix);
    end
    wait_idle();

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph < 4) begin
        tx_idle_pct = 11;
        rx_idle_pct = 72;
      end else if (ph < 8) begin
        tx_idle_pct = 72;
        rx_idle_pct = 11;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      base_y = 8'($urandom_range(235, 16));
      base_u = 8'($urandom_range(192, 64));
      base_v = 8'($urandom_range(192, 64));
      key_pix = convert_pixel(base_y, base_u, base_v, 8'h00, ResetCfg);
      c = make_setting(ph, key_pix[23:0]);
      apply_config(c);
      for (int n = 0; n < BlocksPerPhase; n++) begin
        near = (c.alpha_mode == AlphaKey) && ($urandom_range(9) < 8);
        push_block(random_block(near, base_y, base_u, base_v), 1'b0, '0);
      end
      wait_idle();
    end

    repeat (32) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
